// File: src/sliding_dft_hann_window_defines.svh
// assertion macros used by the top-level file
`ifndef SLIDING_DFT_HANN_WINDOW_DEFINES_SVH
`define SLIDING_DFT_HANN_WINDOW_DEFINES_SVH

// consequent checked in the same cycle
`define SDW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define SDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sdw_pkg.sv
package sdw_pkg;

  localparam int unsigned ACC_W = 32;
  localparam int unsigned PR_W  = 57;
  localparam int unsigned RR_W  = 33;
  localparam int unsigned UR_W  = 35;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CFG_W = 24;

  localparam logic [1:0] CFG_DAMPING       = 2'd0;
  localparam logic [1:0] CFG_DAMPING_POW_N = 2'd1;

  localparam logic [CFG_W-1:0] DAMPING_RST       = 24'hFFFFFF;
  localparam logic [CFG_W-1:0] DAMPING_POW_N_RST = 24'hFFFFC0;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic clr_we;
    logic hist_re;
    logic hist_we;
    logic load_sample;
    logic old_mul;
    logic old_rnd;
    logic issue;
  } sdw_cmd_t;

  typedef struct packed {
    logic en;
    logic pipe_empty;
  } sdw_stat_t;

  function automatic logic signed [ACC_W-1:0] sat32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[ACC_W-1:0];
  endfunction

  // q28 value rounded half up to q1.(tb-1) and saturated
  function automatic longint to_tw(input longint q, input int unsigned tb);
    longint v;
    longint hi;
    v = (q + (longint'(1) <<< (28 - tb))) >>> (29 - tb);
    hi = (longint'(1) <<< (tb - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v;
  endfunction

  function automatic longint tw_cos(input longint unsigned th, input int unsigned tb);
    longint unsigned t2;
    longint unsigned term;
    longint cs;
    t2 = (th * th + (64'd1 << 27)) >> 28;
    term = 64'd1 << 28;
    cs = longint'(term);
    for (int n = 1; n <= 20; n++) begin
      if (term != 0) begin
        term = ((term * t2) >> 28) / 64'((2 * n - 1) * (2 * n));
        cs = ((n & 1) == 1) ? cs - longint'(term) : cs + longint'(term);
      end
    end
    return to_tw(cs, tb);
  endfunction

  function automatic longint tw_sin(input longint unsigned th, input bit neg,
                                    input int unsigned tb);
    longint unsigned t2;
    longint unsigned term;
    longint sn;
    t2 = (th * th + (64'd1 << 27)) >> 28;
    term = th;
    sn = longint'(th);
    for (int n = 1; n <= 20; n++) begin
      if (term != 0) begin
        term = ((term * t2) >> 28) / 64'((2 * n) * (2 * n + 1));
        sn = ((n & 1) == 1) ? sn - longint'(term) : sn + longint'(term);
      end
    end
    return to_tw(neg ? -sn : sn, tb);
  endfunction

  // circular frequency-domain hann: (2c - l - r + 2) >> 2, saturated
  function automatic logic signed [ACC_W-1:0] hann(input logic signed [ACC_W-1:0] l,
                                                   input logic signed [ACC_W-1:0] c,
                                                   input logic signed [ACC_W-1:0] r);
    logic signed [ACC_W+2:0] s;
    s = (35'(c) <<< 1) - 35'(l) - 35'(r) + 35'sd2;
    return sat32(64'(s >>> 2));
  endfunction

endpackage

// File: src/sliding_dft_hann_window.sv
// Damped sliding DFT with a circular Hann window. Each accepted sample
// updates all BINS complex bins and then yields BINS result beats, bin 0
// first, with last_bin_o on bin BINS-1. One bin goes through the update
// pipeline per cycle while the output is not stalled (one accumulator ram
// read and one write per cycle); an item passes through one accept state,
// two states for the oldest-sample term, BINS+2 issue slots and a pipeline
// drain, and a stalled output freezes the pipeline. After reset the block
// clears the sample and accumulator rams before it takes its first sample;
// configuration writes are taken at any time.
`include "sliding_dft_hann_window_defines.svh"

module sliding_dft_hann_window #(
  parameter int unsigned BINS         = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sdw_pkg::IDX_W-1:0]        bin_num_o,
  output logic signed [sdw_pkg::ACC_W-1:0] bin_real_o,
  output logic signed [sdw_pkg::ACC_W-1:0] bin_imag_o,
  output logic                             spectrum_valid_o,
  output logic                             last_bin_o
);

  sdw_pkg::sdw_cmd_t             cmd;
  sdw_pkg::sdw_stat_t            stat;
  logic [$clog2(BINS)-1:0]       hist_addr, clr_addr;
  logic [$clog2(BINS+2)-1:0]     issue_p;
  logic                          full;

  assign cfg_ready_o = 1'b1;

  sdw_ctrl #(.BINS(BINS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .hist_addr_o (hist_addr),
    .clr_addr_o  (clr_addr),
    .issue_p_o   (issue_p),
    .full_o      (full)
  );

  sdw_datapath #(
    .BINS         (BINS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample_i),
    .cmd_i            (cmd),
    .hist_addr_i      (hist_addr),
    .clr_addr_i       (clr_addr),
    .issue_p_i        (issue_p),
    .full_i           (full),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bin_num_o        (bin_num_o),
    .bin_real_o       (bin_real_o),
    .bin_imag_o       (bin_imag_o),
    .spectrum_valid_o (spectrum_valid_o),
    .last_bin_o       (last_bin_o)
  );

  // a taken sample keeps the input closed while its bins are computed
  `SDW_ASSERT_NEXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o,
    "input still open after a sample beat")

  `SDW_ASSERT_SAME(a_last_index, out_valid_o && last_bin_o,
    bin_num_o == sdw_pkg::IDX_W'(BINS - 1), "last bin flag on wrong bin number")

  `SDW_ASSERT_SAME(a_ready_falls_on_beat, $fell(in_ready_o), $past(in_valid_i),
    "input closed without a sample beat")

endmodule

// File: src/sdw_ram.sv
module sdw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sdw_ctrl.sv
module sdw_ctrl #(
  parameter int unsigned BINS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sdw_pkg::sdw_stat_t         stat_i,
  output sdw_pkg::sdw_cmd_t          cmd_o,
  output logic [$clog2(BINS)-1:0]    hist_addr_o,
  output logic [$clog2(BINS)-1:0]    clr_addr_o,
  output logic [$clog2(BINS+2)-1:0]  issue_p_o,
  output logic                       full_o
);

  localparam int unsigned AW = $clog2(BINS);
  localparam int unsigned PW = $clog2(BINS + 2);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OLD1  = 3'd2;
  localparam logic [2:0] ST_OLD2  = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic [PW-1:0] p_q, p_d;
  logic          full_q, full_d;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wpos_d     = wpos_q;
    p_d        = p_q;
    full_d     = full_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(BINS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.hist_re     = 1'b1;
          cmd_o.load_sample = 1'b1;
          state_d = ST_OLD1;
        end
      end
      ST_OLD1: begin
        // oldest sample is out of the ram, overwrite it with the new one
        cmd_o.hist_we = 1'b1;
        cmd_o.old_mul = 1'b1;
        if (wpos_q == AW'(BINS - 1)) begin
          wpos_d = '0;
          full_d = 1'b1;
        end else begin
          wpos_d = wpos_q + 1'b1;
        end
        state_d = ST_OLD2;
      end
      ST_OLD2: begin
        cmd_o.old_rnd = 1'b1;
        p_d = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.en) begin
          if (p_q == PW'(BINS + 1)) state_d = ST_DRAIN;
          else p_d = p_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat_i.pipe_empty) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wpos_q  <= '0;
      p_q     <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wpos_q  <= wpos_d;
      p_q     <= p_d;
      full_q  <= full_d;
    end
  end

  assign hist_addr_o = wpos_q;
  assign clr_addr_o  = clr_q;
  assign issue_p_o   = p_q;
  assign full_o      = full_q;

endmodule

// File: src/sdw_datapath.sv
module sdw_datapath #(
  parameter int unsigned BINS         = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  sdw_pkg::sdw_cmd_t                cmd_i,
  input  logic [$clog2(BINS)-1:0]          hist_addr_i,
  input  logic [$clog2(BINS)-1:0]          clr_addr_i,
  input  logic [$clog2(BINS+2)-1:0]        issue_p_i,
  input  logic                             full_i,
  output sdw_pkg::sdw_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sdw_pkg::IDX_W-1:0]        bin_num_o,
  output logic signed [sdw_pkg::ACC_W-1:0] bin_real_o,
  output logic signed [sdw_pkg::ACC_W-1:0] bin_imag_o,
  output logic                             spectrum_valid_o,
  output logic                             last_bin_o
);

  localparam int unsigned AW   = $clog2(BINS);
  localparam int unsigned PW   = $clog2(BINS + 2);
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned TWB  = TWIDDLE_BITS;
  localparam int unsigned AC   = sdw_pkg::ACC_W;
  localparam int unsigned PRW  = sdw_pkg::PR_W;
  localparam int unsigned RRW  = sdw_pkg::RR_W;
  localparam int unsigned URW  = sdw_pkg::UR_W;
  localparam int unsigned OPW  = SB + 25;
  localparam int unsigned OTW  = SB + 1;
  localparam int unsigned MW   = URW + TWB;
  localparam int unsigned SW   = MW + 1;

  localparam logic signed [OPW-1:0] O_HALF  = OPW'(1) <<< 23;
  localparam logic signed [PRW-1:0] P_HALF  = PRW'(1) <<< 23;
  localparam logic signed [SW-1:0]  T_HALF  = SW'(1) <<< (TWB - 2);

  // configuration
  logic [sdw_pkg::CFG_W-1:0] damp_q, dpn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q <= sdw_pkg::DAMPING_RST;
      dpn_q  <= sdw_pkg::DAMPING_POW_N_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdw_pkg::CFG_DAMPING:       damp_q <= cfg_data_i[sdw_pkg::CFG_W-1:0];
        sdw_pkg::CFG_DAMPING_POW_N: dpn_q  <= cfg_data_i[sdw_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // twiddle rom, built at elaboration
  logic signed [TWB-1:0] tw_cos [BINS];
  logic signed [TWB-1:0] tw_sin [BINS];

  for (genvar g = 0; g < BINS; g++) begin : g_tw
    localparam bit NEG = (2 * g > BINS);
    localparam longint unsigned M  = NEG ? longint'(BINS - g) : longint'(g);
    localparam longint unsigned TH = (M * sdw_pkg::PI_Q30 + BINS) / (2 * BINS);
    localparam longint TC = sdw_pkg::tw_cos(TH, TWB);
    localparam longint TS = sdw_pkg::tw_sin(TH, NEG, TWB);
    assign tw_cos[g] = TWB'(TC);
    assign tw_sin[g] = TWB'(TS);
  end

  // bins go out in the order BINS-1, 0, 1, ... then two tail slots
  function automatic logic [AW-1:0] kof(input logic [PW-1:0] p);
    if (p == '0) return AW'(BINS - 1);
    if (p == PW'(BINS + 1)) return '0;
    return AW'(p - 1'b1);
  endfunction

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;

  // sample history and oldest-sample term
  logic signed [SB-1:0]  nx_q;
  logic [SB-1:0]         hist_rd;
  logic signed [OPW-1:0] opr_q;
  logic signed [OPW-1:0] opr_sum;
  logic signed [OTW-1:0] oterm_q;

  sdw_ram #(.WIDTH(SB), .DEPTH(BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_we | cmd_i.hist_we),
    .waddr_i (cmd_i.clr_we ? clr_addr_i : hist_addr_i),
    .wdata_i (cmd_i.clr_we ? '0 : nx_q),
    .re_i    (cmd_i.hist_re),
    .raddr_i (hist_addr_i),
    .rdata_o (hist_rd)
  );

  assign opr_sum = opr_q + O_HALF;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) nx_q <= sample_i;
    if (cmd_i.old_mul) opr_q <= $signed(hist_rd) * $signed({1'b0, dpn_q});
    if (cmd_i.old_rnd) oterm_q <= $signed(opr_sum[OPW-1:24]);
  end

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [2*AC-1:0] acc_rd;
  logic signed [PRW-1:0] pr_q, pi_q, pr_sum, pi_sum;
  logic signed [TWB-1:0] c2_q, s2_q, c3_q, s3_q;
  logic signed [RRW-1:0] rr_re, rr_im;
  logic signed [URW-1:0] ur_q;
  logic signed [RRW-1:0] ui_q;
  logic signed [MW-1:0]  m_rc_q, m_is_q, m_rs_q, m_ic_q;
  logic signed [SW-1:0]  sum_re, sum_im;
  logic signed [AC-1:0]  new_re_q, new_im_q;
  logic                  wb_we;

  sdw_ram #(.WIDTH(2 * AC), .DEPTH(BINS)) u_acc (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_we | wb_we),
    .waddr_i (cmd_i.clr_we ? clr_addr_i : kof(p5_q)),
    .wdata_i (cmd_i.clr_we ? '0 : {new_re_q, new_im_q}),
    .re_i    (en),
    .raddr_i (kof(issue_p_i)),
    .rdata_o (acc_rd)
  );

  assign pr_sum = pr_q + P_HALF;
  assign pi_sum = pi_q + P_HALF;
  assign rr_re  = $signed(pr_sum[PRW-1:24]);
  assign rr_im  = $signed(pi_sum[PRW-1:24]);
  assign sum_re = SW'(m_rc_q) - SW'(m_is_q) + T_HALF;
  assign sum_im = SW'(m_rs_q) + SW'(m_ic_q) + T_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= issue_p_i;
      // damping of the stored bin
      p2_q <= p1_q;
      pr_q <= $signed(acc_rd[2*AC-1:AC]) * $signed({1'b0, damp_q});
      pi_q <= $signed(acc_rd[AC-1:0]) * $signed({1'b0, damp_q});
      c2_q <= tw_cos[kof(p1_q)];
      s2_q <= tw_sin[kof(p1_q)];
      // comb section of the recursion
      p3_q <= p2_q;
      ur_q <= URW'(rr_re) - URW'(oterm_q) + URW'(nx_q);
      ui_q <= rr_im;
      c3_q <= c2_q;
      s3_q <= s2_q;
      // twiddle rotation
      p4_q   <= p3_q;
      m_rc_q <= ur_q * c3_q;
      m_is_q <= ui_q * s3_q;
      m_rs_q <= ur_q * s3_q;
      m_ic_q <= ui_q * c3_q;
      // round and saturate
      p5_q     <= p4_q;
      new_re_q <= sdw_pkg::sat32(64'($signed(sum_re[SW-1:TWB-1])));
      new_im_q <= sdw_pkg::sat32(64'($signed(sum_im[SW-1:TWB-1])));
    end
  end

  // window stage: three-bin sliding view of the updated spectrum
  logic                 tail, emit, step;
  logic signed [AC-1:0] nv_re, nv_im;
  logic signed [AC-1:0] prev_re_q, prev_im_q, cur_re_q, cur_im_q;
  logic signed [AC-1:0] first_re_q, first_im_q, second_re_q, second_im_q;
  logic [sdw_pkg::IDX_W-1:0] idx_q;
  logic signed [AC-1:0] out_re_q, out_im_q;
  logic                 spec_q, last_q;

  assign step  = en && v5_q;
  assign tail  = p5_q >= PW'(BINS);
  assign emit  = p5_q >= PW'(2);
  assign wb_we = step && !tail;

  always_comb begin
    nv_re = new_re_q;
    nv_im = new_im_q;
    if (tail) begin
      nv_re = (p5_q == PW'(BINS)) ? first_re_q : second_re_q;
      nv_im = (p5_q == PW'(BINS)) ? first_im_q : second_im_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      prev_re_q <= cur_re_q;
      prev_im_q <= cur_im_q;
      cur_re_q  <= nv_re;
      cur_im_q  <= nv_im;
      if (p5_q == '0) begin
        first_re_q <= new_re_q;
        first_im_q <= new_im_q;
      end
      if (p5_q == PW'(1)) begin
        second_re_q <= new_re_q;
        second_im_q <= new_im_q;
      end
      if (emit) begin
        idx_q    <= sdw_pkg::IDX_W'(p5_q - PW'(2));
        out_re_q <= sdw_pkg::hann(prev_re_q, cur_re_q, nv_re);
        out_im_q <= sdw_pkg::hann(prev_im_q, cur_im_q, nv_im);
        spec_q   <= full_i;
        last_q   <= (p5_q == PW'(BINS + 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (step && emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign stat_o.en         = en;
  assign stat_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q);

  assign out_valid_o      = out_valid_q;
  assign bin_num_o        = idx_q;
  assign bin_real_o       = out_re_q;
  assign bin_imag_o       = out_im_q;
  assign spectrum_valid_o = spec_q;
  assign last_bin_o       = last_q;

endmodule
